[rtl/xdm_pkg.sv]
// Shared types and constants of the X-drive mixer with duty ramp.
// Used by xdm_mixer, xdm_slew and the top level x_drive_mixer_with_ramp.
// Has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package xdm_pkg;

  localparam int MOTOR_CNT  = 4;
  localparam int AXIS_W     = 10;
  localparam int TRIG_W     = 10;
  localparam int DUTY_W     = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int PROD_W     = 18;
  localparam int AXIS_SHIFT = 9;
  localparam int SCALED_W   = PROD_W - AXIS_SHIFT;
  localparam int MIX_W      = 12;

  localparam logic signed [AXIS_W-1:0] DEAD_ZONE    = 10'sd80;
  localparam logic signed [MIX_W-1:0]  TRIGGER_TURN = 12'sd80;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 8'd255;
  localparam logic [DUTY_W-1:0] SLEW_STEP_RST  = 8'd5;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_LIMIT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SLEW_STEP  = 1'd1;

  typedef struct packed {
    logic        [TRIG_W-1:0] trig_right;
    logic        [TRIG_W-1:0] trig_left;
    logic signed [AXIS_W-1:0] turn;
    logic signed [AXIS_W-1:0] fwd;
  } in_item_t;

  typedef struct packed {
    logic                           neutral;
    logic [MOTOR_CNT-1:0]           way;
    logic [MOTOR_CNT-1:0][DUTY_W-1:0] duty;
  } tgt_t;

endpackage

`default_nettype wire

[rtl/x_drive_mixer_with_ramp.sv]
// X-drive motor mixer with duty ramp, top level.
// Holds the configuration registers and the input register; instantiates
// xdm_mixer and xdm_slew. Depends on xdm_pkg.
//
// Usage: one joystick sample is a transfer on the in_ channel; each sample
// gives exactly one result transfer on the out_ channel with four ramped
// duties and four direction bits. Results come out in sample order.
// A sample passes three registers in turn, and out_tvalid rises when it
// reaches the last one. The three registers are the input register, the
// target register (dead zone, scaling and mixing with one 10x8 multiply per
// axis) and the applied-duty register, which is also the result register.
// One sample is taken in every cycle while the receiver keeps out_tready high;
// the applied-duty registers update once per sample, so consecutive samples
// ramp correctly back to back.
// A stalled receiver holds the result; the two upstream stages still fill,
// after which in_tready drops until out_tready returns.
// Reset (rst_n low, synchronous) empties the pipeline, clears the applied
// duties and direction bits, and sets duty_limit to 255 and slew_step to 5.
// Configuration writes (cfg_addr 0: duty_limit, 1: slew_step) take effect at
// the clock edge with cfg_we high and are meant for an idle block.
`timescale 1ns / 1ps
`default_nettype none

module x_drive_mixer_with_ramp
  import xdm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // stick_forward[9:0], stick_turn[19:10], trigger_left[29:20],
  // trigger_right[39:30]
  input  wire logic [39:0]           in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // duty_one[7:0], duty_two[15:8], duty_three[23:16], duty_four[31:24],
  // way_one[32], way_two[33], way_three[34], way_four[35], zero [39:36]
  output logic [39:0]                out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DUTY_W-1:0]     cfg_wdata
);

  logic [DUTY_W-1:0]                 duty_limit_r;
  logic [DUTY_W-1:0]                 slew_step_r;
  logic                              in_valid_r;
  in_item_t                          in_item_r;
  logic                              mix_ready;
  logic                              tgt_valid;
  tgt_t                              tgt;
  logic                              tgt_ready;
  logic [MOTOR_CNT-1:0][DUTY_W-1:0]  res_duty;
  logic [MOTOR_CNT-1:0]              res_way;

  assign in_tready = !in_valid_r || mix_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_limit_r <= DUTY_LIMIT_RST;
      slew_step_r  <= SLEW_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DUTY_LIMIT: duty_limit_r <= cfg_wdata;
        REG_SLEW_STEP:  slew_step_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_tdata;
    end
  end

  xdm_mixer u_mixer (
    .clk        (clk),
    .rst_n      (rst_n),
    .duty_limit (duty_limit_r),
    .src_valid  (in_valid_r),
    .src_item   (in_item_r),
    .src_ready  (mix_ready),
    .tgt_valid  (tgt_valid),
    .tgt        (tgt),
    .tgt_ready  (tgt_ready)
  );

  xdm_slew u_slew (
    .clk       (clk),
    .rst_n     (rst_n),
    .slew_step (slew_step_r),
    .tgt_valid (tgt_valid),
    .tgt       (tgt),
    .tgt_ready (tgt_ready),
    .res_valid (out_tvalid),
    .res_duty  (res_duty),
    .res_way   (res_way),
    .res_ready (out_tready)
  );

  assign out_tdata = {4'b0000, res_way, res_duty};

endmodule

`default_nettype wire

[rtl/xdm_mixer.sv]
// Dead zone, axis scaling, trigger rotation and four-motor mixing.
// Registers one set of target duties and direction bits per transfer.
// Depends on xdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xdm_mixer
  import xdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [DUTY_W-1:0] duty_limit,
  input  wire logic              src_valid,
  input  wire in_item_t          src_item,
  output logic                   src_ready,
  output logic                   tgt_valid,
  output tgt_t                   tgt,
  input  wire logic              tgt_ready
);

  logic                       tgt_valid_r;
  tgt_t                       tgt_r;
  tgt_t                       tgt_nxt;
  logic                       load;
  logic signed [AXIS_W-1:0]   fwd_dz;
  logic signed [AXIS_W-1:0]   turn_dz;
  logic signed [PROD_W-1:0]   lim_s;
  logic signed [PROD_W-1:0]   fwd_prod;
  logic signed [PROD_W-1:0]   turn_prod;
  logic signed [PROD_W-1:0]   fwd_adj;
  logic signed [PROD_W-1:0]   turn_adj;
  logic signed [MIX_W-1:0]    down;
  logic signed [MIX_W-1:0]    left;
  logic signed [MIX_W-1:0]    rot;
  logic signed [MIX_W-1:0]    mix [MOTOR_CNT];
  logic        [MIX_W-1:0]    mag [MOTOR_CNT];
  logic                       tl;
  logic                       tr;

  assign src_ready = !tgt_valid_r || tgt_ready;
  assign load      = src_valid && src_ready;
  assign tgt_valid = tgt_valid_r;
  assign tgt       = tgt_r;

  always_comb begin
    fwd_dz  = ((src_item.fwd > -DEAD_ZONE) && (src_item.fwd < DEAD_ZONE)) ? '0 : src_item.fwd;
    turn_dz = ((src_item.turn > -DEAD_ZONE) && (src_item.turn < DEAD_ZONE)) ? '0 : src_item.turn;
    tl      = (src_item.trig_left != '0);
    tr      = (src_item.trig_right != '0);

    lim_s     = $signed({{(PROD_W-DUTY_W){1'b0}}, duty_limit});
    fwd_prod  = $signed({{(PROD_W-AXIS_W){fwd_dz[AXIS_W-1]}}, fwd_dz}) * lim_s;
    turn_prod = $signed({{(PROD_W-AXIS_W){turn_dz[AXIS_W-1]}}, turn_dz}) * lim_s;

    // Division by the full-scale axis value truncates toward zero: a negative
    // product is biased by one less than the divisor before the shift.
    fwd_adj  = fwd_prod + $signed({{(PROD_W-AXIS_SHIFT){1'b0}},
                                   {AXIS_SHIFT{fwd_prod[PROD_W-1]}}});
    turn_adj = turn_prod + $signed({{(PROD_W-AXIS_SHIFT){1'b0}},
                                    {AXIS_SHIFT{turn_prod[PROD_W-1]}}});
    down = $signed({{(MIX_W-SCALED_W){fwd_adj[PROD_W-1]}}, fwd_adj[PROD_W-1:AXIS_SHIFT]});
    left = $signed({{(MIX_W-SCALED_W){turn_adj[PROD_W-1]}}, turn_adj[PROD_W-1:AXIS_SHIFT]});

    rot = '0;
    if (tr) begin
      rot = rot + TRIGGER_TURN;
    end
    if (tl) begin
      rot = rot - TRIGGER_TURN;
    end

    mix[0] = -down + left + rot;
    mix[1] = -down - left - rot;
    mix[2] = down - left + rot;
    mix[3] = down + left - rot;

    tgt_nxt.neutral = (fwd_dz == '0) && (turn_dz == '0) && !tl && !tr;
    tgt_nxt.way[0]  = (mix[0] > 0);
    tgt_nxt.way[1]  = (mix[1] > 0);
    tgt_nxt.way[2]  = (mix[2] < 0);
    tgt_nxt.way[3]  = (mix[3] < 0);

    for (int k = 0; k < MOTOR_CNT; k++) begin
      mag[k] = mix[k][MIX_W-1] ? MIX_W'(-mix[k]) : MIX_W'(mix[k]);
      if (tgt_nxt.neutral) begin
        tgt_nxt.duty[k] = '0;
      end else if (mag[k] > {{(MIX_W-DUTY_W){1'b0}}, duty_limit}) begin
        tgt_nxt.duty[k] = duty_limit;
      end else begin
        tgt_nxt.duty[k] = mag[k][DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_valid_r <= 1'b0;
    end else if (src_ready) begin
      tgt_valid_r <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tgt_r <= tgt_nxt;
    end
  end

  a_neutral_zero: assert property (@(posedge clk) disable iff (!rst_n)
    tgt_valid_r && tgt_r.neutral |-> (tgt_r.duty == '0))
    else $error("neutral sample produced a nonzero target duty");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> tgt_valid_r)
    else $error("accepted sample did not reach the target stage");

endmodule

`default_nettype wire

[rtl/xdm_slew.sv]
// Slew-rate limiter: moves each applied duty toward its target and holds
// the direction bits. The state registers are also the result register.
// Depends on xdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xdm_slew
  import xdm_pkg::*;
(
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [DUTY_W-1:0]                slew_step,
  input  wire logic                             tgt_valid,
  input  wire tgt_t                             tgt,
  output logic                                  tgt_ready,
  output logic                                  res_valid,
  output logic [MOTOR_CNT-1:0][DUTY_W-1:0]      res_duty,
  output logic [MOTOR_CNT-1:0]                  res_way,
  input  wire logic                             res_ready
);

  logic                              res_valid_r;
  logic [MOTOR_CNT-1:0][DUTY_W-1:0]  applied_r;
  logic [MOTOR_CNT-1:0][DUTY_W-1:0]  applied_nxt;
  logic [MOTOR_CNT-1:0]              way_r;
  logic                              load;

  function automatic logic [DUTY_W-1:0] slew_to(
    input logic [DUTY_W-1:0] cur,
    input logic [DUTY_W-1:0] goal,
    input logic [DUTY_W-1:0] step
  );
    logic [DUTY_W-1:0] res;
    if (cur < goal) begin
      res = ((goal - cur) > step) ? cur + step : goal;
    end else if (cur > goal) begin
      res = ((cur - goal) > step) ? cur - step : goal;
    end else begin
      res = goal;
    end
    return res;
  endfunction

  assign tgt_ready = !res_valid_r || res_ready;
  assign load      = tgt_valid && tgt_ready;
  assign res_valid = res_valid_r;
  assign res_duty  = applied_r;
  assign res_way   = way_r;

  always_comb begin
    for (int k = 0; k < MOTOR_CNT; k++) begin
      applied_nxt[k] = slew_to(applied_r[k], tgt.duty[k], slew_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      applied_r   <= '0;
      way_r       <= '0;
    end else begin
      if (tgt_ready) begin
        res_valid_r <= tgt_valid;
      end
      if (load) begin
        applied_r <= applied_nxt;
        // A neutral sample keeps the previous directions.
        if (!tgt.neutral) begin
          way_r <= tgt.way;
        end
      end
    end
  end

  a_neutral_hold_way: assert property (@(posedge clk) disable iff (!rst_n)
    load && tgt.neutral |=> $stable(way_r))
    else $error("direction bits changed on a neutral sample");

  a_zero_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    load && (slew_step == '0) |=> $stable(applied_r))
    else $error("applied duty moved with a zero slew step");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for x_drive_mixer_with_ramp: joystick samples go in on the
// in_ stream, and each ramped duty and direction result is checked against a predictor.
// Depends on xdm_pkg and the RTL of the block; reads nothing else.
`timescale 1ns / 1ps

module testbench;
  import xdm_pkg::*;

  localparam int DEAD_BAND  = 80;
  localparam int FULL_SCALE = 512;
  localparam int SPIN       = 80;
  localparam int WAY_LSB    = MOTOR_CNT * DUTY_W;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 200;

  // Predicts the ramped duties and direction bits, and holds them until the block answers.
  class duty_ramp_scoreboard;
    logic [DUTY_W-1:0] duty_limit;
    logic [DUTY_W-1:0] slew_step;
    int                applied[MOTOR_CNT];
    logic              held_way[MOTOR_CNT];
    logic [39:0]       expected_drive[$];
    int                mismatch_count;
    string             duty_label[MOTOR_CNT] = '{"duty_one", "duty_two", "duty_three",
                                                 "duty_four"};
    string             way_label[MOTOR_CNT] = '{"way_one", "way_two", "way_three",
                                                "way_four"};

    function new();
      duty_limit = DUTY_LIMIT_RST;
      slew_step = SLEW_STEP_RST;
      mismatch_count = 0;
      for (int i = 0; i < MOTOR_CNT; i++) begin
        applied[i] = 0;
        held_way[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [DUTY_W-1:0] val);
      if (idx == REG_DUTY_LIMIT) duty_limit = val;
      else if (idx == REG_SLEW_STEP) slew_step = val;
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    function int dead_band(int v);
      return (v > -DEAD_BAND && v < DEAD_BAND) ? 0 : v;
    endfunction

    function void note_sample(in_item_t s);
      int f, t, lim, down, left, rot, mag, step;
      int mix[MOTOR_CNT];
      int target[MOTOR_CNT];
      logic [39:0] r;
      f = dead_band($signed(s.fwd));
      t = dead_band($signed(s.turn));
      lim = duty_limit;
      step = slew_step;
      for (int i = 0; i < MOTOR_CNT; i++) target[i] = 0;
      // A neutral sample aims every motor at zero and keeps the direction bits.
      if (f != 0 || t != 0 || s.trig_left != 0 || s.trig_right != 0) begin
        down = (f * lim) / FULL_SCALE;
        left = (t * lim) / FULL_SCALE;
        rot = 0;
        if (s.trig_right != 0) rot += SPIN;
        if (s.trig_left != 0) rot -= SPIN;
        mix[0] = -down + left + rot;
        mix[1] = -down - left - rot;
        mix[2] = down - left + rot;
        mix[3] = down + left - rot;
        held_way[0] = mix[0] > 0;
        held_way[1] = mix[1] > 0;
        held_way[2] = mix[2] < 0;
        held_way[3] = mix[3] < 0;
        for (int i = 0; i < MOTOR_CNT; i++) begin
          mag = (mix[i] < 0) ? -mix[i] : mix[i];
          target[i] = (mag > lim) ? lim : mag;
        end
      end
      r = '0;
      for (int i = 0; i < MOTOR_CNT; i++) begin
        if (applied[i] < target[i])
          applied[i] = (target[i] - applied[i] > step) ? applied[i] + step : target[i];
        else if (applied[i] > target[i])
          applied[i] = (applied[i] - target[i] > step) ? applied[i] - step : target[i];
        r[DUTY_W*i +: DUTY_W] = DUTY_W'(applied[i]);
        r[WAY_LSB+i] = held_way[i];
      end
      expected_drive.push_back(r);
    endfunction

    function void check_result(logic [39:0] got);
      logic [39:0] want;
      if (expected_drive.size() == 0) begin
        $error("result transfer %h arrived with nothing expected", got);
        mismatch_count++;
        return;
      end
      want = expected_drive.pop_front();
      for (int i = 0; i < MOTOR_CNT; i++) begin
        if (got[DUTY_W*i +: DUTY_W] !== want[DUTY_W*i +: DUTY_W]) begin
          $error("%s: expected %0d, actual %0d", duty_label[i],
                 want[DUTY_W*i +: DUTY_W], got[DUTY_W*i +: DUTY_W]);
          mismatch_count++;
        end
        if (got[WAY_LSB+i] !== want[WAY_LSB+i]) begin
          $error("%s: expected %0b, actual %0b", way_label[i], want[WAY_LSB+i],
                 got[WAY_LSB+i]);
          mismatch_count++;
        end
      end
      if (got[39:WAY_LSB+MOTOR_CNT] !== '0) begin
        $error("padding: expected 0, actual %h", got[39:WAY_LSB+MOTOR_CNT]);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // stick_forward[9:0], stick_turn[19:10], trigger_left[29:20], trigger_right[39:30]
  logic [39:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // duty_one[7:0], duty_two[15:8], duty_three[23:16], duty_four[31:24],
  // way_one[32], way_two[33], way_three[34], way_four[35], zero [39:36]
  logic [39:0]           out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DUTY_W-1:0]     cfg_wdata;

  bit                    calm;
  bit                    hold_off_req;
  duty_ramp_scoreboard   sb;

  x_drive_mixer_with_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly no gap or a short one, now and then a long one; none in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_sample(int f, int t, int l, int r);
    in_item_t s;
    s.fwd = AXIS_W'(f);
    s.turn = AXIS_W'(t);
    s.trig_left = TRIG_W'(l);
    s.trig_right = TRIG_W'(r);
    return s;
  endfunction

  function automatic int pick_axis();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? 511 : -512;
      1, 2: v = $urandom_range(0, 1) ? $urandom_range(70, 90) : -$urandom_range(70, 90);
      3: v = $urandom_range(0, 1) ? $urandom_range(0, 79) : -$urandom_range(0, 79);
      default: v = $signed(AXIS_W'($urandom));
    endcase
    return v;
  endfunction

  function automatic int pick_trigger();
    case ($urandom_range(0, 5))
      0, 1, 2: return 0;
      3: return 1 << $urandom_range(0, TRIG_W - 1);
      4: return TRIG_W'(1023);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic in_item_t random_sample();
    // About one sample in eight sits inside the dead band with the triggers released.
    if ($urandom_range(0, 7) == 0)
      return make_sample($urandom_range(0, 158) - 79, $urandom_range(0, 158) - 79, 0, 0);
    return make_sample(pick_axis(), pick_axis(), pick_trigger(), pick_trigger());
  endfunction

  task automatic send_sample(input in_item_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Stops offering and waits for every outstanding result.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DUTY_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = 120;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    int lim_set, step_set, wait_cycles;
    sb = new();
    calm = 1'b0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_DUTY_LIMIT;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples with the reset settings.
    send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(-512, 0, 0, 0));
    send_sample(make_sample(511, 0, 0, 0));
    send_sample(make_sample(0, -512, 0, 0));
    send_sample(make_sample(0, 511, 0, 0));
    send_sample(make_sample(79, 0, 0, 0));
    send_sample(make_sample(-80, 0, 0, 0));
    send_sample(make_sample(0, 80, 0, 0));
    send_sample(make_sample(0, -79, 0, 0));
    send_sample(make_sample(0, 0, 1023, 0));
    send_sample(make_sample(0, 0, 0, 1));
    // Both triggers cancel: every mix is exactly zero and all direction bits clear.
    send_sample(make_sample(0, 0, 1023, 512));
    send_sample(make_sample(-512, -512, 0, 1023));
    send_sample(make_sample(511, 511, 1023, 0));
    send_sample(make_sample(-40, 60, 0, 0));
    drain();

    // Zero duty limit: targets all zero while direction bits still follow the mixes.
    write_reg(REG_DUTY_LIMIT, 8'd0);
    write_reg(REG_SLEW_STEP, 8'd255);
    send_sample(make_sample(-512, 300, 0, 1));
    send_sample(make_sample(0, 0, 0, 0));
    drain();
    write_reg(REG_DUTY_LIMIT, 8'd255);
    send_sample(make_sample(-512, 0, 0, 0));
    send_sample(make_sample(0, 0, 0, 0));
    drain();
    // Zero slew step: the applied duties stay where they are.
    write_reg(REG_SLEW_STEP, 8'd0);
    send_sample(make_sample(511, -512, 7, 0));
    send_sample(make_sample(-300, 200, 0, 0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lim_set = 255; step_set = 5; end
        1: begin lim_set = 0;   step_set = 255; end
        2: begin lim_set = 255; step_set = 255; end
        3: begin lim_set = 255; step_set = 0; end
        4: begin lim_set = 1;   step_set = 1; end
        5: begin lim_set = 128; step_set = 10; end
        default: begin
          lim_set = $urandom_range(0, 255);
          step_set = $urandom_range(0, 255);
        end
      endcase
      write_reg(REG_DUTY_LIMIT, DUTY_W'(lim_set));
      write_reg(REG_SLEW_STEP, DUTY_W'(step_set));
      calm = (p == 2 || p == 6);
      for (int i = 0; i < PHASE_LEN; i++) begin
        // The long hold-off lets the pipeline fill so that in_tready drops.
        if (p == 0 && i == 50) hold_off_req = 1'b1;
        if (p == 4 && i == 100) drain();
        send_sample(random_sample());
      end
      drain();
    end
    calm = 1'b0;

    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.mismatch_count++;
    end
    repeat (8) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[x_drive_mixer_with_ramp.f]
rtl/xdm_pkg.sv
rtl/xdm_mixer.sv
rtl/xdm_slew.sv
rtl/x_drive_mixer_with_ramp.sv
test/testbench.sv
